// ===== src/wmpd_pkg.sv =====
// Package for the wildcard motif presence detector.
// Holds the field widths, the register map and the reset values.
// Has no dependencies. Every module of the block imports it.
package wmpd_pkg;

  localparam int unsigned MaxMotifLenDef = 20;  // default motif capacity
  localparam int unsigned CfgCharCount   = 20;  // motif characters held by the registers
  localparam int unsigned CharW          = 8;
  localparam int unsigned LenW           = 5;
  localparam int unsigned CfgIdxW        = 3;
  localparam int unsigned CfgDataW       = 64;
  localparam int unsigned InDataW        = 8;
  localparam int unsigned OutDataW       = 8;

  localparam logic [LenW-1:0]  LenReset      = 5'd1;
  localparam logic [CharW-1:0] WildcardReset = 8'd45;  // ASCII '-'

  typedef enum logic [CfgIdxW-1:0] {
    RegMotifLen   = 3'd0,
    RegCharsLow   = 3'd1,
    RegCharsMid   = 3'd2,
    RegCharsHigh  = 3'd3,
    RegWildcard   = 3'd4
  } cfg_reg_e;

  // Settings that the matcher needs, apart from the motif characters.
  typedef struct packed {
    logic [LenW-1:0]  len;   // clamped length, 1 to the motif capacity
    logic [CharW-1:0] wild;  // wildcard code
  } cfg_ctrl_t;

endpackage

// ===== src/wmpd_cfg.sv =====
// Configuration registers of the wildcard motif presence detector.
// Holds the register file, clamps the motif length and unpacks the motif.
// Depends on wmpd_pkg.
module wmpd_cfg import wmpd_pkg::*; #(
  parameter int unsigned MaxMotifLen = MaxMotifLenDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CfgIdxW-1:0]           cfg_idx_i,
  input  logic [CfgDataW-1:0]          cfg_wdata_i,
  output cfg_ctrl_t                    ctrl_o,
  output logic [MaxMotifLen*CharW-1:0] motif_o
);

  logic [LenW-1:0]  len_q;
  logic [63:0]      low_q;
  logic [63:0]      mid_q;
  logic [31:0]      high_q;
  logic [CharW-1:0] wild_q;
  logic [CfgCharCount*CharW-1:0] chars_all;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= LenReset;
      low_q  <= '0;
      mid_q  <= '0;
      high_q <= '0;
      wild_q <= WildcardReset;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        RegMotifLen:  len_q  <= cfg_wdata_i[LenW-1:0];
        RegCharsLow:  low_q  <= cfg_wdata_i;
        RegCharsMid:  mid_q  <= cfg_wdata_i;
        RegCharsHigh: high_q <= cfg_wdata_i[31:0];
        RegWildcard:  wild_q <= cfg_wdata_i[CharW-1:0];
        default: ;
      endcase
    end
  end

  // A length of zero acts as one; anything above the capacity is cut to it.
  always_comb begin
    ctrl_o.wild = wild_q;
    if (len_q == '0) begin
      ctrl_o.len = LenW'(1);
    end else if (len_q > LenW'(MaxMotifLen)) begin
      ctrl_o.len = LenW'(MaxMotifLen);
    end else begin
      ctrl_o.len = len_q;
    end
  end

  assign chars_all = {high_q, mid_q, low_q};

  // Positions beyond what the registers hold read as character zero.
  for (genvar i = 0; i < MaxMotifLen; i++) begin : g_char
    if (i < CfgCharCount) begin : g_reg
      assign motif_o[i*CharW +: CharW] = chars_all[i*CharW +: CharW];
    end else begin : g_zero
      assign motif_o[i*CharW +: CharW] = '0;
    end
  end

endmodule

// ===== src/wmpd_match.sv =====
// Shift-and matcher of the wildcard motif presence detector.
// Keeps the prefix-match bits and the sticky hit flag, one update per character.
// Depends on wmpd_pkg.
module wmpd_match import wmpd_pkg::*; #(
  parameter int unsigned MaxMotifLen = MaxMotifLenDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  logic [CharW-1:0]             char_i,
  input  logic                         last_i,
  input  cfg_ctrl_t                    ctrl_i,
  input  logic [MaxMotifLen*CharW-1:0] motif_i,
  output logic                         found_o
);

  logic [MaxMotifLen-1:0] prefix_q, prefix_d, prefix_upd;
  logic [MaxMotifLen-1:0] match_vec, len_mask, last_sel;
  logic                   hit_q, hit_d, hit_now;

  always_comb begin
    for (int i = 0; i < MaxMotifLen; i++) begin
      match_vec[i] = (motif_i[i*CharW +: CharW] == ctrl_i.wild) ||
                     (motif_i[i*CharW +: CharW] == char_i);
      len_mask[i]  = LenW'(i) < ctrl_i.len;
      last_sel[i]  = LenW'(i) == (ctrl_i.len - LenW'(1));
    end
  end

  assign prefix_upd = ((prefix_q << 1) | MaxMotifLen'(1)) & match_vec & len_mask;
  assign hit_now    = |(prefix_upd & last_sel);
  assign found_o    = hit_q | hit_now;

  // The end of a sequence clears all matching state for the next one.
  always_comb begin
    prefix_d = prefix_q;
    hit_d    = hit_q;
    if (step_i) begin
      if (last_i) begin
        prefix_d = '0;
        hit_d    = 1'b0;
      end else begin
        prefix_d = prefix_upd;
        hit_d    = found_o;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q <= '0;
      hit_q    <= 1'b0;
    end else begin
      prefix_q <= prefix_d;
      hit_q    <= hit_d;
    end
  end

endmodule

// ===== src/wildcard_motif_presence_detector.sv =====
// Top level of the wildcard motif presence detector.
// Instantiates the configuration registers and the shift-and matcher.
// Depends on wmpd_pkg, wmpd_cfg and wmpd_match.

// The block scans a stream of characters, one request per character, and
// splits it into sequences at each request that carries tlast. For every
// sequence it returns exactly one result request, on the character that
// carries tlast, whose bit 0 says whether the configured motif occurred
// anywhere in the sequence. A motif character equal to the wildcard code
// matches any character; a sequence shorter than the motif never hits.
// The block takes one character every clock cycle for as long as results
// are taken; a character request is captured in the input register at
// acceptance, is then matched by a single parallel compare against every
// motif position with a one-step shift-and update, and its result, if any,
// is registered in the output register. The output register decouples the
// two sides: characters without tlast keep flowing while a result waits,
// and only a second tlast character stalls until the first result is taken.
// Configuration is written through a plain write port; the user must write
// it only while the block is idle, as the block itself does not enforce it.
// Register indexes beyond the last one are ignored.
module wildcard_motif_presence_detector import wmpd_pkg::*; #(
  parameter int unsigned MaxMotifLen = MaxMotifLenDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write port.
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_wdata_i,
  // Character stream.
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [InDataW-1:0]   s_axis_tdata,   // [7:0] seq_char
  input  logic                 s_axis_tlast,   // end_of_sequence
  // Result stream.
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutDataW-1:0]  m_axis_tdata    // [0] motif_found, [7:1] zero
);

  cfg_ctrl_t                    ctrl;
  logic [MaxMotifLen*CharW-1:0] motif;

  logic             s1_valid_q, s1_valid_d;
  logic [CharW-1:0] s1_char_q;
  logic             s1_last_q;
  logic             out_valid_q, out_valid_d;
  logic             out_found_q;
  logic             found;
  logic             in_acc, out_free, s1_go;

  wmpd_cfg #(
    .MaxMotifLen (MaxMotifLen)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ctrl_o      (ctrl),
    .motif_o     (motif)
  );

  // A character without tlast produces no result, so it can always move on;
  // a tlast character needs room in the output register.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign s1_go         = s1_valid_q && (!s1_last_q || out_free);
  assign s_axis_tready = !s1_valid_q || s1_go;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  wmpd_match #(
    .MaxMotifLen (MaxMotifLen)
  ) u_match (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (s1_go),
    .char_i  (s1_char_q),
    .last_i  (s1_last_q),
    .ctrl_i  (ctrl),
    .motif_i (motif),
    .found_o (found)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_go) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_go && s1_last_q) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_char_q <= s_axis_tdata[CharW-1:0];
      s1_last_q <= s_axis_tlast;
    end
    if (s1_go && s1_last_q) begin
      out_found_q <= found;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW-1){1'b0}}, out_found_q};

endmodule

// ===== src/wmpd_checker.sv =====
// Port-level checker for the wildcard motif presence detector.
// Watches the stream ports only and is bound to the top level below.
// Depends on wmpd_pkg.
module wmpd_checker import wmpd_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  // With no result pending the input side can never be blocked.
  a_ready_when_out_empty: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready
  ) else $error("input stalled while no result was pending");

  // Only the flag bit of a result may be set.
  a_result_pad_zero: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[OutDataW-1:1] == '0)
  ) else $error("result padding bits not zero");

  // A stalled result stays and keeps its value.
  a_result_holds: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
  ) else $error("stalled result dropped or changed");

endmodule

bind wildcard_motif_presence_detector wmpd_checker u_wmpd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
